@@ hdl/piecewise_quadratic_eval_macros.svh @@
// Assertion macros shared by the piecewise quadratic evaluator RTL.
// Depends on nothing; taken in by the modules that check their own logic.
`ifndef PIECEWISE_QUADRATIC_EVAL_MACROS_SVH
`define PIECEWISE_QUADRATIC_EVAL_MACROS_SVH
// Consequent must hold in the same cycle as the antecedent.
`define PQE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Consequent must hold a fixed number of cycles after the antecedent.
`define PQE_ASSERT_DLY(label, clk, rst, ante, dly, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);
`endif

@@ hdl/pqe_pkg.sv @@
// Types, widths and codes shared by the piecewise quadratic evaluator.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package pqe_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_BITS   = 16;
   localparam int MAX_NODES   = 64;
   localparam int MIN_NODES   = 2;
   localparam int IDX_W       = $clog2(MAX_NODES);
   localparam int COUNT_W     = 7;
   localparam int COUNT_RESET = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // dx is one bit wider than the operands; the shared multiplier is DX_W square
   localparam int DX_W   = DATA_W + 1;
   localparam int MUL_W  = 2 * DX_W;
   localparam int T_W    = MUL_W - FRAC_BITS + 1;
   localparam int T_LO_W = (T_W - 1) / 2;
   localparam int T_HI_W = T_W - T_LO_W;
   localparam int ACC_W  = DX_W + T_W;
   localparam int SUM_W  = ACC_W - FRAC_BITS + 1;

   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } op_type;

   typedef enum logic [PADDR_W-3:0] {
      CSR_NODE_COUNT = 1'b0
   } csr_reg_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         entry_index;
      logic signed [DATA_W-1:0] node_pos;
      logic signed [DATA_W-1:0] coef_const;
      logic signed [DATA_W-1:0] coef_lin;
      logic signed [DATA_W-1:0] coef_quad;
      logic signed [DATA_W-1:0] query_x;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         segment;
      logic                     out_of_range;
      logic                     saturated;
   } rsp_type;

   // one table entry; for an evaluate word pos carries the query abscissa
   typedef struct packed {
      logic signed [DATA_W-1:0] pos;
      logic signed [DATA_W-1:0] coef_const;
      logic signed [DATA_W-1:0] coef_lin;
      logic signed [DATA_W-1:0] coef_quad;
   } entry_type;

   typedef struct packed {
      logic             is_eval;
      logic [IDX_W-1:0] index;
      entry_type        entry;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]         seg;
      logic                     oor;
      logic signed [DX_W-1:0]   dx;
      logic signed [DATA_W-1:0] coef_const;
      logic signed [DATA_W-1:0] coef_lin;
      logic signed [DATA_W-1:0] coef_quad;
   } job_type;

   typedef enum logic [2:0] {
      SR_IDLE,
      SR_LOW,
      SR_HIGH,
      SR_PROBE,
      SR_FETCH
   } search_state_type;

   typedef enum logic [2:0] {
      AR_IDLE,
      AR_MUL_Q,
      AR_SUM_T,
      AR_MUL_LO,
      AR_MUL_HI,
      AR_ACC,
      AR_FIN
   } arith_state_type;

endpackage
`default_nettype wire

@@ hdl/piecewise_quadratic_eval.sv @@
// Piecewise quadratic evaluator, top level: register port and the three front-to-back parts.
// Depends on pqe_pkg, pqe_front, pqe_search and pqe_arith.
//
// Use:
//   req_*  : request words, valid/ready. op selects a table write (node position plus
//            the three coefficients of the segment starting there) or an evaluation at
//            query_x. A write gives no response word; an evaluation gives exactly one.
//   rsp_*  : response words, valid/ready: saturated Q16.16 value, segment used,
//            out-of-range flag (query clamped to an end segment) and saturation flag.
//   psel.. : register port; word address 0 holds node_count (reset 2).
// Flow:
//   A write word leaves the queue and is written into the table in the same cycle, so
//   writes stream at one per cycle while the search holds no evaluation. An evaluation
//   makes at most ceil(log2(node_count - 1)) probes of the single table read port in the
//   search (none above the last node or below the first node), then passes to the
//   multiply sequencer, which runs alongside the next search.
// Reset clears the queue, both sequencers and the response valid flag; the table keeps
// whatever it held and must be written before it is evaluated. A stalled receiver
// holds the response word; the queue then fills and req_ready drops.
`default_nettype none
module piecewise_quadratic_eval import pqe_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_word,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0]      prdata,
   output logic                    pready
);

   logic [COUNT_W-1:0] node_count_ff;
   csr_reg_type        csr_reg;
   logic               csr_write;
   logic               cmd_valid;
   cmd_type            cmd_word;
   logic               cmd_pop;
   logic               job_valid;
   job_type            job_word;
   logic               job_ready;

   // Register port: no wait states; decode the word address only.
   assign pready    = 1'b1;
   assign csr_reg   = csr_reg_type'(paddr[PADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_W'(COUNT_RESET);
      end else if (csr_write && csr_reg == CSR_NODE_COUNT) begin
         node_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_reg)
         CSR_NODE_COUNT: prdata = PDATA_W'(node_count_ff);
         default:        prdata = '0;
      endcase
   end

   // Front: classify each word and hold it in a short queue.
   pqe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop)
   );

   // Back, first half: write the table or search it and fetch the segment.
   pqe_search u_search (
      .clock      (clock),
      .reset      (reset),
      .node_count (node_count_ff),
      .cmd_valid  (cmd_valid),
      .cmd_word   (cmd_word),
      .cmd_pop    (cmd_pop),
      .job_valid  (job_valid),
      .job_word   (job_word),
      .job_ready  (job_ready)
   );

   // Back, second half: evaluate the quadratic and hold the response word.
   pqe_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_word  (job_word),
      .job_ready (job_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

@@ hdl/pqe_front.sv @@
// Front end: accepts request words, classifies them and queues them.
// Depends on pqe_pkg.
`default_nettype none
module pqe_front import pqe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_word,
   output logic         cmd_valid,
   output cmd_type      cmd_word,
   input  wire logic    cmd_pop
);

   cmd_type              cmd_in;
   cmd_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]    count_ff;
   logic                 push;
   logic                 pop;

   // fold the query abscissa into the position slot of an evaluate word
   always_comb begin
      cmd_in.is_eval           = (req_word.op == OP_EVAL);
      cmd_in.index             = req_word.entry_index;
      cmd_in.entry.pos         = cmd_in.is_eval ? req_word.query_x : req_word.node_pos;
      cmd_in.entry.coef_const  = req_word.coef_const;
      cmd_in.entry.coef_lin    = req_word.coef_lin;
      cmd_in.entry.coef_quad   = req_word.coef_quad;
   end

   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_word  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
`default_nettype wire

@@ hdl/pqe_search.sv @@
// Back end, first half: node table, table writes and the binary segment search.
// Depends on pqe_pkg and piecewise_quadratic_eval_macros.svh.
`default_nettype none
`include "piecewise_quadratic_eval_macros.svh"
module pqe_search import pqe_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [COUNT_W-1:0] node_count,
   input  wire logic               cmd_valid,
   input  wire cmd_type            cmd_word,
   output logic                    cmd_pop,
   output logic                    job_valid,
   output job_type                 job_word,
   input  wire logic               job_ready
);

   search_state_type         state_ff;
   search_state_type         state_in;
   entry_type                tbl_mem [MAX_NODES];
   entry_type                rd_data_ff;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     mem_we;
   logic signed [DATA_W-1:0] x_ff;
   logic [IDX_W-1:0]         last_ff;
   logic [IDX_W-1:0]         last_in;
   logic [IDX_W-1:0]         lo_ff;
   logic [IDX_W-1:0]         hi_ff;
   logic [IDX_W-1:0]         mid_ff;
   logic [IDX_W-1:0]         seg_ff;
   logic                     oor_ff;
   logic [IDX_W-1:0]         sel_lo;
   logic [IDX_W-1:0]         sel_hi;
   logic [IDX_W:0]           mid_sum;
   logic [IDX_W-1:0]         mid_next;
   logic                     sel_done;
   logic                     x_below;
   logic                     x_above;
   logic                     job_valid_ff;
   job_type                  job_ff;
   job_type                  job_in;
   logic                     job_load;
   logic                     job_take;

   // clamp the node count into the supported range, keep the last node index
   always_comb begin
      if (node_count < COUNT_W'(MIN_NODES)) begin
         last_in = IDX_W'(MIN_NODES - 1);
      end else if (node_count > COUNT_W'(MAX_NODES)) begin
         last_in = IDX_W'(MAX_NODES - 1);
      end else begin
         last_in = IDX_W'(node_count - COUNT_W'(1));
      end
   end

   assign x_below = (x_ff < rd_data_ff.pos);
   assign x_above = (x_ff > rd_data_ff.pos);

   // open the search window after the last node, then narrow it by the node just read
   always_comb begin
      sel_lo = lo_ff;
      sel_hi = hi_ff;
      if (state_ff == SR_HIGH) begin
         sel_lo = '0;
         sel_hi = last_ff - IDX_W'(1);
      end else if (!x_below) begin
         sel_lo = mid_ff;
      end else begin
         sel_hi = mid_ff - IDX_W'(1);
      end
      mid_sum  = {1'b0, sel_lo} + {1'b0, sel_hi} + (IDX_W + 1)'(1);
      mid_next = mid_sum[IDX_W:1];
      sel_done = (sel_lo >= sel_hi);
   end

   assign job_take = job_valid_ff && job_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SR_IDLE:  if (cmd_valid && cmd_word.is_eval) state_in = SR_LOW;
         SR_LOW:   state_in = x_below ? SR_FETCH : SR_HIGH;
         SR_HIGH:  state_in = (x_above || sel_done) ? SR_FETCH : SR_PROBE;
         SR_PROBE: if (sel_done) state_in = SR_FETCH;
         SR_FETCH: if (job_load) state_in = SR_IDLE;
         default:  state_in = SR_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop  = 1'b0;
      mem_we   = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      job_load = 1'b0;
      unique case (state_ff)
         SR_IDLE: begin
            cmd_pop = cmd_valid;
            mem_we  = cmd_valid && !cmd_word.is_eval;
            rd_en   = cmd_valid && cmd_word.is_eval;
         end
         SR_LOW: begin
            rd_en   = 1'b1;
            rd_addr = x_below ? '0 : last_ff;
         end
         SR_HIGH: begin
            rd_en   = 1'b1;
            rd_addr = x_above ? sel_hi : (sel_done ? sel_lo : mid_next);
         end
         SR_PROBE: begin
            rd_en   = 1'b1;
            rd_addr = sel_done ? sel_lo : mid_next;
         end
         SR_FETCH: begin
            job_load = !job_valid_ff || job_take;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tbl_mem[cmd_word.index] <= cmd_word.entry;
      end
      if (rd_en) begin
         rd_data_ff <= tbl_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SR_IDLE && cmd_valid) begin
         x_ff    <= cmd_word.entry.pos;
         last_ff <= last_in;
         oor_ff  <= 1'b0;
      end
      if (state_ff == SR_LOW && x_below) begin
         seg_ff <= '0;
         oor_ff <= 1'b1;
      end
      if (state_ff == SR_HIGH && x_above) begin
         seg_ff <= sel_hi;
         oor_ff <= 1'b1;
      end
      if ((state_ff == SR_HIGH && !x_above) || state_ff == SR_PROBE) begin
         lo_ff  <= sel_lo;
         hi_ff  <= sel_hi;
         mid_ff <= mid_next;
         seg_ff <= sel_lo;
      end
   end

   always_comb begin
      job_in.seg        = seg_ff;
      job_in.oor        = oor_ff;
      job_in.dx         = DX_W'(x_ff) - DX_W'(rd_data_ff.pos);
      job_in.coef_const = rd_data_ff.coef_const;
      job_in.coef_lin   = rd_data_ff.coef_lin;
      job_in.coef_quad  = rd_data_ff.coef_quad;
   end

   always_ff @(posedge clock) begin
      if (job_load) begin
         job_ff <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SR_IDLE;
         job_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (job_load) begin
            job_valid_ff <= 1'b1;
         end else if (job_take) begin
            job_valid_ff <= 1'b0;
         end
      end
   end

   assign job_valid = job_valid_ff;
   assign job_word  = job_ff;

   `PQE_ASSERT_IMP(a_probe_window, clock, reset, state_ff == SR_PROBE, lo_ff < hi_ff && mid_ff > lo_ff && mid_ff <= hi_ff, "probe window out of order")
   `PQE_ASSERT_IMP(a_seg_in_range, clock, reset, state_ff == SR_FETCH, seg_ff < last_ff, "segment beyond last node")
   `PQE_ASSERT_IMP(a_clamp_seg, clock, reset, state_ff == SR_FETCH && oor_ff, seg_ff == '0 || seg_ff == last_ff - IDX_W'(1), "clamped query not on an end segment")

endmodule
`default_nettype wire

@@ hdl/pqe_arith.sv @@
// Back end, second half: quadratic evaluation on one shared multiplier and result register.
// Depends on pqe_pkg and piecewise_quadratic_eval_macros.svh.
`default_nettype none
`include "piecewise_quadratic_eval_macros.svh"
module pqe_arith import pqe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job_word,
   output logic         job_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_word
);

   arith_state_type          state_ff;
   arith_state_type          state_in;
   job_type                  job_ff;
   logic signed [DX_W-1:0]   mul_a;
   logic signed [DX_W-1:0]   mul_b;
   logic signed [MUL_W-1:0]  mul_p;
   logic signed [MUL_W-1:0]  prod_ff;
   logic signed [T_W-1:0]    t_ff;
   logic signed [T_W-1:0]    t_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  sum;
   logic [SUM_W-DATA_W:0]    sum_top;
   logic                     sat;
   logic signed [DATA_W-1:0] value;
   logic                     job_accept;
   logic                     prod_en;
   logic                     t_en;
   logic                     acc_lo_en;
   logic                     acc_add_en;
   logic                     out_load;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_word_ff;

   // t = a1 + floor(a2*dx), then dx*t as low and high halves of t
   always_comb begin
      mul_a = job_ff.dx;
      case (state_ff)
         AR_MUL_Q:  mul_b = DX_W'(job_ff.coef_quad);
         AR_MUL_LO: mul_b = $signed({{(DX_W-T_LO_W){1'b0}}, t_ff[T_LO_W-1:0]});
         AR_MUL_HI: mul_b = DX_W'($signed(t_ff[T_W-1:T_LO_W]));
         default:   mul_b = '0;
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign t_in  = T_W'(job_ff.coef_lin) + T_W'(prod_ff >>> FRAC_BITS);

   // add a0 and clip to the output width
   assign sum     = SUM_W'(job_ff.coef_const) + SUM_W'(acc_ff >>> FRAC_BITS);
   assign sum_top = sum[SUM_W-1:DATA_W-1];
   assign sat     = !((&sum_top) || !(|sum_top));
   assign value   = sat ? (sum[SUM_W-1] ? VALUE_MIN : VALUE_MAX) : sum[DATA_W-1:0];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         AR_IDLE:   if (job_valid) state_in = AR_MUL_Q;
         AR_MUL_Q:  state_in = AR_SUM_T;
         AR_SUM_T:  state_in = AR_MUL_LO;
         AR_MUL_LO: state_in = AR_MUL_HI;
         AR_MUL_HI: state_in = AR_ACC;
         AR_ACC:    state_in = AR_FIN;
         AR_FIN:    if (out_load) state_in = AR_IDLE;
         default:   state_in = AR_IDLE;
      endcase
   end

   always_comb begin
      job_ready  = 1'b0;
      prod_en    = 1'b0;
      t_en       = 1'b0;
      acc_lo_en  = 1'b0;
      acc_add_en = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff) inside
         AR_IDLE:             job_ready = 1'b1;
         AR_MUL_Q, AR_MUL_LO: prod_en = 1'b1;
         AR_SUM_T:            t_en = 1'b1;
         AR_MUL_HI: begin
            prod_en   = 1'b1;
            acc_lo_en = 1'b1;
         end
         AR_ACC:              acc_add_en = 1'b1;
         AR_FIN:              out_load = !rsp_valid_ff || rsp_ready;
         default:             job_ready = 1'b0;
      endcase
   end

   assign job_accept = job_valid && job_ready;

   always_ff @(posedge clock) begin
      if (job_accept) begin
         job_ff <= job_word;
      end
      if (prod_en) begin
         prod_ff <= mul_p;
      end
      if (t_en) begin
         t_ff <= t_in;
      end
      if (acc_lo_en) begin
         acc_ff <= ACC_W'(prod_ff);
      end else if (acc_add_en) begin
         acc_ff <= acc_ff + (ACC_W'(prod_ff) <<< T_LO_W);
      end
      if (out_load) begin
         rsp_word_ff.value        <= value;
         rsp_word_ff.segment      <= job_ff.seg;
         rsp_word_ff.out_of_range <= job_ff.oor;
         rsp_word_ff.saturated    <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= AR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `PQE_ASSERT_DLY(a_fixed_sequence, clock, reset, job_accept, 6, state_ff == AR_FIN, "evaluation sequence length changed")
   `PQE_ASSERT_IMP(a_sat_extreme, clock, reset, rsp_valid_ff && rsp_word_ff.saturated, rsp_word_ff.value == VALUE_MAX || rsp_word_ff.value == VALUE_MIN, "saturated value not at a limit")
   `PQE_ASSERT_DLY(a_rsp_held, clock, reset, rsp_valid_ff && !rsp_ready, 1, rsp_valid_ff && $stable(rsp_word_ff), "response word changed while stalled")

endmodule
`default_nettype wire
